// ===== rtl/zfst_pkg.sv =====
// ----------------------------------------------------------------------------
// zfst_pkg
// Shared types, codes and helpers for the zoom/focus stepper tracker.
// ----------------------------------------------------------------------------
package zfst_pkg;

   localparam int TABLE_SEGMENTS_DEF = 16;
   localparam int DIV_BITS = 32;
   localparam int DIV_CNT_W = $clog2(DIV_BITS);

   typedef enum logic [2:0] {
      CMD_TICK        = 3'd0,
      CMD_MOVE_TO     = 3'd1,
      CMD_MOVE_LIMIT  = 3'd2,
      CMD_HOME        = 3'd3,
      CMD_STOP        = 3'd4,
      CMD_SET_MAIN    = 3'd5,
      CMD_SET_FOLLOW  = 3'd6,
      CMD_LOAD_TABLE  = 3'd7
   } cmd_type;

   typedef enum logic [2:0] {
      CSR_MAIN_PHASE_COUNT   = 3'd0,
      CSR_FOLLOW_PHASE_COUNT = 3'd1,
      CSR_STEP_PERIOD        = 3'd2,
      CSR_FOLLOW_LIMIT       = 3'd3,
      CSR_LOWER_LIMIT        = 3'd4,
      CSR_UPPER_LIMIT        = 3'd5,
      CSR_HOME_POSITION      = 3'd6,
      CSR_UNUSED             = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic start;
      logic cap_lo;
      logic load_mul;
      logic mul;
      logic div_init;
      logic div_step;
      logic finish;
      logic extrap;
   } ctl_cmd_type;

   typedef struct packed {
      logic need_interp;
      logic z_less;
   } dp_status_type;

   // Advances or retreats a drive phase, wrapping at the effective count.
   function automatic logic [5:0] phase_move(input logic [5:0] ph,
                                             input logic [6:0] cnt,
                                             input logic up);
      logic [6:0] c;
      logic [6:0] nxt;
      begin
         c = (cnt == 7'd0) ? 7'd1 : ((cnt > 7'd64) ? 7'd64 : cnt);
         nxt = {1'b0, ph} + 7'd1;
         if (up) begin
            phase_move = (nxt > c - 7'd1) ? 6'd0 : nxt[5:0];
         end else begin
            phase_move = (ph == 6'd0) ? 6'(c - 7'd1) : ph - 6'd1;
         end
      end
   endfunction

endpackage

// ===== rtl/zfst_dpath.sv =====
// ----------------------------------------------------------------------------
// zfst_dpath
// Motor state, configuration, breakpoint tables and the interpolation unit
// with its multiplier and shift-subtract divider.
// ----------------------------------------------------------------------------
module zfst_dpath #(
   parameter int TABLE_SEGMENTS = zfst_pkg::TABLE_SEGMENTS_DEF,
   parameter int AW = $clog2(TABLE_SEGMENTS)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  zfst_pkg::ctl_cmd_type   ctl,
   input  logic [AW-1:0]           rd_addr,
   output zfst_pkg::dp_status_type status,
   input  logic [2:0]              req_command,
   input  logic signed [15:0]      req_position_value,
   input  logic                    req_forward,
   input  logic                    req_follow_enable,
   input  logic [3:0]              req_table_index,
   input  logic signed [15:0]      req_table_zoom,
   input  logic signed [15:0]      req_table_focus,
   input  logic                    csr_we,
   input  logic [2:0]              csr_index,
   input  logic [15:0]             csr_data,
   output logic signed [15:0]      rsp_main_position,
   output logic signed [15:0]      rsp_follow_position,
   output logic [5:0]              rsp_main_phase,
   output logic [5:0]              rsp_follow_phase,
   output logic                    rsp_main_stepped,
   output logic                    rsp_follow_stepped,
   output logic                    rsp_moving,
   output logic                    rsp_release_res
);
   import zfst_pkg::*;

   logic [6:0] mpc_ff, fpc_ff;
   logic [15:0] sp_ff;
   logic signed [15:0] fl_ff, ll_ff, ul_ff, hp_ff;

   logic signed [15:0] zp_ff, zp_in, zg_ff, zg_in, fp_ff, fp_in, fg_ff, fg_in;
   logic [5:0] zph_ff, zph_in, fph_ff, fph_in;
   logic [15:0] pc_ff, pc_in;
   logic busy_ff, busy_in, trk_ff, trk_in;
   logic zst_ff, zst_in, fst_ff, fst_in, rel_ff, rel_in;

   logic signed [15:0] zb_mem [TABLE_SEGMENTS];
   logic signed [15:0] fb_mem [TABLE_SEGMENTS];
   logic signed [15:0] zb_rd_ff, fb_rd_ff, zlo_ff, flo_ff, base_ff;
   logic signed [16:0] dz_ff, df_ff, den_ff;
   logic signed [33:0] prod_ff;
   logic [31:0] quo_ff;
   logic [15:0] rem_ff, dmag_ff;
   logic neg_ff, dzero_ff;

   logic signed [15:0] t_zg, t_fg, goal, interp_res;
   logic [15:0] pc_inc;
   logic t_busy, t_trk, do_step, fw, up, need_interp;
   logic signed [16:0] zref;
   logic [16:0] trial;
   logic signed [33:0] qs, rsum;
   logic [33:0] pabs;
   logic [16:0] dabs;
   logic wr_ok;
   logic [AW-1:0] wr_addr;

   assign wr_ok = 32'(req_table_index) < TABLE_SEGMENTS;
   assign wr_addr = AW'(req_table_index);

   always_ff @(posedge clock) begin
      if (reset) begin
         mpc_ff <= 7'd8;
         fpc_ff <= 7'd8;
         sp_ff <= 16'd1;
         fl_ff <= 16'sd32767;
         ll_ff <= 16'sd0;
         ul_ff <= 16'sd3000;
         hp_ff <= 16'sd0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_MAIN_PHASE_COUNT: mpc_ff <= csr_data[6:0];
            CSR_FOLLOW_PHASE_COUNT: fpc_ff <= csr_data[6:0];
            CSR_STEP_PERIOD: sp_ff <= csr_data;
            CSR_FOLLOW_LIMIT: fl_ff <= csr_data;
            CSR_LOWER_LIMIT: ll_ff <= csr_data;
            CSR_UPPER_LIMIT: ul_ff <= csr_data;
            CSR_HOME_POSITION: hp_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (cmd_type'(req_command))
         CMD_MOVE_TO: goal = req_position_value;
         CMD_MOVE_LIMIT: goal = req_forward ? ul_ff : ll_ff;
         default: goal = hp_ff;
      endcase
   end

   always_comb begin
      zp_in = zp_ff; zg_in = zg_ff; fp_in = fp_ff; fg_in = fg_ff;
      zph_in = zph_ff; fph_in = fph_ff; pc_in = pc_ff;
      busy_in = busy_ff; trk_in = trk_ff;
      zst_in = zst_ff; fst_in = fst_ff; rel_in = rel_ff;
      t_zg = zg_ff; t_fg = fg_ff; t_busy = busy_ff; t_trk = trk_ff;
      do_step = 1'b0; need_interp = 1'b0; fw = 1'b0; up = 1'b0;
      pc_inc = pc_ff + 16'd1;
      if (ctl.start) begin
         zst_in = 1'b0; fst_in = 1'b0; rel_in = 1'b0;
         case (cmd_type'(req_command))
            CMD_TICK: begin
               if (busy_ff) begin
                  if (pc_inc >= sp_ff) begin
                     pc_in = 16'd0;
                     do_step = 1'b1;
                  end else begin
                     pc_in = pc_inc;
                  end
               end
            end
            CMD_MOVE_TO, CMD_MOVE_LIMIT, CMD_HOME: begin
               t_zg = goal;
               t_busy = 1'b1;
               t_trk = (cmd_type'(req_command) == CMD_HOME) ? 1'b0 : req_follow_enable;
               t_fg = fp_ff;
               pc_in = 16'd0;
               do_step = 1'b1;
            end
            CMD_STOP: begin
               if (busy_ff) begin
                  t_busy = 1'b0; t_trk = 1'b0; rel_in = 1'b1;
               end
            end
            CMD_SET_MAIN: zp_in = req_position_value;
            CMD_SET_FOLLOW: fp_in = req_position_value;
            default: ;
         endcase
         fw = t_trk && (t_fg != fp_ff) && (t_fg <= fl_ff);
         if (do_step) begin
            if (fw) begin
               up = fp_ff < t_fg;
               fph_in = phase_move(fph_ff, fpc_ff, up);
               fp_in = up ? fp_ff + 16'sd1 : fp_ff - 16'sd1;
               fst_in = 1'b1;
            end else if (zp_ff != t_zg) begin
               up = zp_ff < t_zg;
               zph_in = phase_move(zph_ff, mpc_ff, up);
               zp_in = up ? zp_ff + 16'sd1 : zp_ff - 16'sd1;
               zst_in = 1'b1;
               need_interp = t_trk;
            end else begin
               t_busy = 1'b0; t_trk = 1'b0; rel_in = 1'b1;
            end
         end
         zg_in = t_zg; fg_in = t_fg; busy_in = t_busy; trk_in = t_trk;
      end
      if (ctl.finish) begin
         fg_in = interp_res;
         if (trk_ff && (interp_res != fp_ff) && (interp_res <= fl_ff)) begin
            up = fp_ff < interp_res;
            fph_in = phase_move(fph_ff, fpc_ff, up);
            fp_in = up ? fp_ff + 16'sd1 : fp_ff - 16'sd1;
            fst_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zp_ff <= '0; zg_ff <= '0; fp_ff <= '0; fg_ff <= '0;
         zph_ff <= '0; fph_ff <= '0; pc_ff <= '0;
         busy_ff <= 1'b0; trk_ff <= 1'b0;
         zst_ff <= 1'b0; fst_ff <= 1'b0; rel_ff <= 1'b0;
      end else begin
         zp_ff <= zp_in; zg_ff <= zg_in; fp_ff <= fp_in; fg_ff <= fg_in;
         zph_ff <= zph_in; fph_ff <= fph_in; pc_ff <= pc_in;
         busy_ff <= busy_in; trk_ff <= trk_in;
         zst_ff <= zst_in; fst_ff <= fst_in; rel_ff <= rel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start && (cmd_type'(req_command) == CMD_LOAD_TABLE) && wr_ok) begin
         zb_mem[wr_addr] <= req_table_zoom;
         fb_mem[wr_addr] <= req_table_focus;
      end
      zb_rd_ff <= zb_mem[rd_addr];
      fb_rd_ff <= fb_mem[rd_addr];
   end

   assign zref = ctl.extrap ? 17'(zb_rd_ff) : 17'(zlo_ff);
   assign pabs = prod_ff[33] ? 34'(-prod_ff) : 34'(prod_ff);
   assign dabs = den_ff[16] ? 17'(-den_ff) : 17'(den_ff);
   assign trial = {rem_ff, quo_ff[31]};

   always_ff @(posedge clock) begin
      if (ctl.cap_lo) begin
         zlo_ff <= zb_rd_ff;
         flo_ff <= fb_rd_ff;
      end
      if (ctl.load_mul) begin
         dz_ff <= 17'(zp_ff) - zref;
         df_ff <= 17'(fb_rd_ff) - 17'(flo_ff);
         den_ff <= 17'(zb_rd_ff) - 17'(zlo_ff);
         base_ff <= ctl.extrap ? fb_rd_ff : flo_ff;
      end
      if (ctl.mul) begin
         prod_ff <= dz_ff * df_ff;
      end
      if (ctl.div_init) begin
         quo_ff <= pabs[31:0];
         rem_ff <= '0;
         dmag_ff <= dabs[15:0];
         neg_ff <= prod_ff[33] ^ den_ff[16];
         dzero_ff <= (den_ff == 17'sd0);
      end
      if (ctl.div_step) begin
         if (trial >= {1'b0, dmag_ff}) begin
            rem_ff <= 16'(trial - {1'b0, dmag_ff});
            quo_ff <= {quo_ff[30:0], 1'b1};
         end else begin
            rem_ff <= trial[15:0];
            quo_ff <= {quo_ff[30:0], 1'b0};
         end
      end
   end

   always_comb begin
      if (dzero_ff) begin
         qs = '0;
      end else begin
         qs = neg_ff ? -$signed({2'b00, quo_ff}) : $signed({2'b00, quo_ff});
      end
      rsum = 34'(base_ff) + qs;
      if (rsum > 34'sd32767) begin
         interp_res = 16'sd32767;
      end else if (rsum < -34'sd32768) begin
         interp_res = -16'sd32768;
      end else begin
         interp_res = rsum[15:0];
      end
   end

   assign status.need_interp = need_interp;
   assign status.z_less = zp_ff < zb_rd_ff;

   assign rsp_main_position = zp_ff;
   assign rsp_follow_position = fp_ff;
   assign rsp_main_phase = zph_ff;
   assign rsp_follow_phase = fph_ff;
   assign rsp_main_stepped = zst_ff;
   assign rsp_follow_stepped = fst_ff;
   assign rsp_moving = busy_ff;
   assign rsp_release_res = rel_ff;

endmodule

// ===== rtl/zfst_ctrl.sv =====
// ----------------------------------------------------------------------------
// zfst_ctrl
// Sequencer for the handshakes, the breakpoint search and the divider.
// ----------------------------------------------------------------------------
module zfst_ctrl #(
   parameter int TABLE_SEGMENTS = zfst_pkg::TABLE_SEGMENTS_DEF,
   parameter int AW = $clog2(TABLE_SEGMENTS)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  zfst_pkg::dp_status_type status,
   output zfst_pkg::ctl_cmd_type   ctl,
   output logic [AW-1:0]           rd_addr
);
   import zfst_pkg::*;

   typedef enum logic [9:0] {
      ST_IDLE      = 10'b0000000001,
      ST_SCAN_ADDR = 10'b0000000010,
      ST_SCAN_TEST = 10'b0000000100,
      ST_RD_LO     = 10'b0000001000,
      ST_RD_HI     = 10'b0000010000,
      ST_MUL_A     = 10'b0000100000,
      ST_MUL_B     = 10'b0001000000,
      ST_DIV_INIT  = 10'b0010000000,
      ST_DIV_RUN   = 10'b0100000000,
      ST_FIN       = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   logic [AW:0] idx_ff, idx_in, seg_ff, seg_in, lo, hi;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept;

   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      if (seg_ff == '0) begin
         lo = '0; hi = '0;
      end else if (seg_ff == (AW+1)'(TABLE_SEGMENTS)) begin
         lo = (AW+1)'(TABLE_SEGMENTS - 2); hi = (AW+1)'(TABLE_SEGMENTS - 1);
      end else begin
         lo = seg_ff - 1'b1; hi = seg_ff;
      end
   end

   always_comb begin
      state_in = state_ff; idx_in = idx_ff; seg_in = seg_ff; cnt_in = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ctl = '0;
      ctl.extrap = (seg_ff == (AW+1)'(TABLE_SEGMENTS));
      rd_addr = idx_ff[AW-1:0];
      case (state_ff)
         ST_IDLE: begin
            ctl.start = accept;
            if (accept) begin
               if (status.need_interp) begin
                  idx_in = '0;
                  state_in = ST_SCAN_ADDR;
               end else begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         ST_SCAN_ADDR: state_in = ST_SCAN_TEST;
         ST_SCAN_TEST: begin
            if (status.z_less) begin
               seg_in = idx_ff;
               state_in = ST_RD_LO;
            end else if (idx_ff == (AW+1)'(TABLE_SEGMENTS - 1)) begin
               seg_in = (AW+1)'(TABLE_SEGMENTS);
               state_in = ST_RD_LO;
            end else begin
               idx_in = idx_ff + 1'b1;
               state_in = ST_SCAN_ADDR;
            end
         end
         ST_RD_LO: begin
            rd_addr = lo[AW-1:0];
            state_in = ST_RD_HI;
         end
         ST_RD_HI: begin
            rd_addr = hi[AW-1:0];
            ctl.cap_lo = 1'b1;
            state_in = ST_MUL_A;
         end
         ST_MUL_A: begin
            ctl.load_mul = 1'b1;
            state_in = ST_MUL_B;
         end
         ST_MUL_B: begin
            ctl.mul = 1'b1;
            state_in = ST_DIV_INIT;
         end
         ST_DIV_INIT: begin
            ctl.div_init = 1'b1;
            cnt_in = '0;
            state_in = ST_DIV_RUN;
         end
         ST_DIV_RUN: begin
            ctl.div_step = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_BITS - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            ctl.finish = 1'b1;
            rsp_valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         idx_ff <= '0;
         seg_ff <= '0;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff <= idx_in;
         seg_ff <= seg_in;
         cnt_ff <= cnt_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_beat_while_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !rsp_valid_ff)
      else $error("result offered while interpolation runs");
   a_div_to_fin: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV_RUN && cnt_ff == DIV_CNT_W'(DIV_BITS - 1)) |=> (state_ff == ST_FIN))
      else $error("divider did not finish after its last step");
   a_fin_gives_beat: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("interpolated item gave no result");
`endif

endmodule

// ===== rtl/zoom_focus_stepper_tracker_core.sv =====
// ----------------------------------------------------------------------------
// zoom_focus_stepper_tracker_core
// Zoom stepper controller with focus tracking over a breakpoint curve.
// ----------------------------------------------------------------------------
// Each accepted command gives exactly one result beat. Commands that need
// no focus interpolation give their result the cycle after acceptance. A
// zoom step with follow enabled runs the interpolation unit: a linear search
// of the breakpoint memory, a multiply, and a one-bit-per-cycle divider of
// 32 steps. The next command is taken once no interpolation runs and the
// result register is free or being emptied.
module zoom_focus_stepper_tracker_core #(
   parameter int TABLE_SEGMENTS = zfst_pkg::TABLE_SEGMENTS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_command,
   input  logic signed [15:0] req_position_value,
   input  logic               req_forward,
   input  logic               req_follow_enable,
   input  logic [3:0]         req_table_index,
   input  logic signed [15:0] req_table_zoom,
   input  logic signed [15:0] req_table_focus,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_main_position,
   output logic signed [15:0] rsp_follow_position,
   output logic [5:0]         rsp_main_phase,
   output logic [5:0]         rsp_follow_phase,
   output logic               rsp_main_stepped,
   output logic               rsp_follow_stepped,
   output logic               rsp_moving,
   output logic               rsp_release_res,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_data
);
   import zfst_pkg::*;

   localparam int AW = $clog2(TABLE_SEGMENTS);

   ctl_cmd_type ctl;
   dp_status_type status;
   logic [AW-1:0] rd_addr;

   assign csr_ready = 1'b1;

   zfst_ctrl #(.TABLE_SEGMENTS(TABLE_SEGMENTS), .AW(AW)) u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .status(status), .ctl(ctl), .rd_addr(rd_addr)
   );

   zfst_dpath #(.TABLE_SEGMENTS(TABLE_SEGMENTS), .AW(AW)) u_dpath (
      .clock(clock), .reset(reset),
      .ctl(ctl), .rd_addr(rd_addr), .status(status),
      .req_command(req_command), .req_position_value(req_position_value),
      .req_forward(req_forward), .req_follow_enable(req_follow_enable),
      .req_table_index(req_table_index), .req_table_zoom(req_table_zoom),
      .req_table_focus(req_table_focus),
      .csr_we(csr_valid && csr_ready), .csr_index(csr_index), .csr_data(csr_data),
      .rsp_main_position(rsp_main_position), .rsp_follow_position(rsp_follow_position),
      .rsp_main_phase(rsp_main_phase), .rsp_follow_phase(rsp_follow_phase),
      .rsp_main_stepped(rsp_main_stepped), .rsp_follow_stepped(rsp_follow_stepped),
      .rsp_moving(rsp_moving), .rsp_release_res(rsp_release_res)
   );

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Zoom/focus stepper tracker testbench
// Drives command beats through directed rows and random traffic across several
// register settings and idle phases, predicts every result beat with a local
// behavioral model of the tracker and compares each field as it arrives.
// ----------------------------------------------------------------------------
module tb;
   import zfst_pkg::*;

   typedef struct {
      logic [15:0] zpos;
      logic [15:0] fpos;
      logic [5:0]  zph;
      logic [5:0]  fph;
      logic        zst;
      logic        fst;
      logic        mov;
      logic        rel;
   } motor_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [2:0] req_command = CMD_TICK;
   logic signed [15:0] req_position_value = '0;
   logic req_forward = 1'b0;
   logic req_follow_enable = 1'b0;
   logic [3:0] req_table_index = '0;
   logic signed [15:0] req_table_zoom = '0;
   logic signed [15:0] req_table_focus = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [15:0] rsp_main_position, rsp_follow_position;
   logic [5:0] rsp_main_phase, rsp_follow_phase;
   logic rsp_main_stepped, rsp_follow_stepped, rsp_moving, rsp_release_res;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = CSR_MAIN_PHASE_COUNT;
   logic [15:0] csr_data = '0;

   zoom_focus_stepper_tracker_core uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state.
   int unsigned m_zcnt, m_fcnt, m_period;
   int m_flimit, m_lower, m_upper, m_home;
   int m_zpos, m_zgoal, m_fpos, m_fgoal;
   int unsigned m_zph, m_fph, m_pcount;
   bit m_busy, m_track, m_zst, m_fst, m_rel;
   int m_tz[16], m_tf[16];

   motor_beat_type pending_beats[$];
   int errors = 0;
   int send_idle = 0, recv_stall = 0;
   int hold_cycles = 0;
   longint quiet = 0;

   function automatic int wrap16(input int v);
      return int'(signed'(v[15:0]));
   endfunction

   function automatic int unsigned next_phase(input int unsigned ph, input int unsigned cnt,
                                              input bit up);
      int unsigned c;
      c = (cnt < 1) ? 1 : ((cnt > 64) ? 64 : cnt);
      if (up) return (ph + 1 > c - 1) ? 0 : ph + 1;
      return (ph == 0) ? c - 1 : ph - 1;
   endfunction

   function automatic int focus_curve(input int z);
      int i;
      longint num, den, r;
      for (i = 0; i < 16; i++) if (z < m_tz[i]) break;
      if (i == 0) return m_tf[0];
      if (i < 16) begin
         num = longint'(z - m_tz[i-1]) * longint'(m_tf[i] - m_tf[i-1]);
         den = longint'(m_tz[i]) - m_tz[i-1];
      end else begin
         num = longint'(z - m_tz[i-1]) * longint'(m_tf[i-1] - m_tf[i-2]);
         den = longint'(m_tz[i-1]) - m_tz[i-2];
      end
      r = m_tf[i-1];
      if (den != 0) r += num / den;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return int'(r);
   endfunction

   function automatic bit focus_due();
      return m_track && m_fgoal != m_fpos && m_fgoal <= m_flimit;
   endfunction

   task automatic step_focus();
      bit up;
      up = m_fpos < m_fgoal;
      m_fph = next_phase(m_fph, m_fcnt, up);
      m_fpos = wrap16(m_fpos + (up ? 1 : -1));
      m_fst = 1;
   endtask

   task automatic run_step();
      bit up;
      if (focus_due()) begin
         step_focus();
      end else if (m_zpos != m_zgoal) begin
         up = m_zpos < m_zgoal;
         m_zph = next_phase(m_zph, m_zcnt, up);
         m_zpos = wrap16(m_zpos + (up ? 1 : -1));
         m_zst = 1;
         if (m_track) begin
            m_fgoal = focus_curve(m_zpos);
            if (focus_due()) step_focus();
         end
      end else begin
         m_busy = 0;
         m_track = 0;
         m_rel = 1;
      end
   endtask

   task automatic begin_move(input int goal, input bit fol);
      m_zgoal = goal;
      m_busy = 1;
      m_track = fol;
      m_pcount = 0;
      m_fgoal = m_fpos;
      run_step();
   endtask

   task automatic predict_motion(input logic [2:0] cmd, input logic signed [15:0] pv,
                                 input bit fwd, input bit fen, input logic [3:0] ti,
                                 input logic signed [15:0] tz, input logic signed [15:0] tf);
      motor_beat_type b;
      m_zst = 0;
      m_fst = 0;
      m_rel = 0;
      case (cmd)
         CMD_TICK: begin
            if (m_busy) begin
               m_pcount = (m_pcount + 1) & 16'hFFFF;
               if (m_pcount >= m_period) begin
                  m_pcount = 0;
                  run_step();
               end
            end
         end
         CMD_MOVE_TO: begin_move(pv, fen);
         CMD_MOVE_LIMIT: begin_move(fwd ? m_upper : m_lower, fen);
         CMD_HOME: begin_move(m_home, 0);
         CMD_STOP: begin
            if (m_busy) begin
               m_busy = 0;
               m_track = 0;
               m_rel = 1;
            end
         end
         CMD_SET_MAIN: m_zpos = pv;
         CMD_SET_FOLLOW: m_fpos = pv;
         default: begin
            m_tz[ti] = tz;
            m_tf[ti] = tf;
         end
      endcase
      b.zpos = m_zpos[15:0];
      b.fpos = m_fpos[15:0];
      b.zph = m_zph[5:0];
      b.fph = m_fph[5:0];
      b.zst = m_zst;
      b.fst = m_fst;
      b.mov = m_busy;
      b.rel = m_rel;
      pending_beats.push_back(b);
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // Result checking.
   always @(posedge clock) begin
      motor_beat_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_beats.size() == 0) begin
            report_mismatch("unexpected beat", 1, 0);
         end else begin
            e = pending_beats.pop_front();
            if (rsp_main_position !== e.zpos)
               report_mismatch("main_position", rsp_main_position, signed'(e.zpos));
            if (rsp_follow_position !== e.fpos)
               report_mismatch("follow_position", rsp_follow_position, signed'(e.fpos));
            if (rsp_main_phase !== e.zph) report_mismatch("main_phase", rsp_main_phase, e.zph);
            if (rsp_follow_phase !== e.fph)
               report_mismatch("follow_phase", rsp_follow_phase, e.fph);
            if (rsp_main_stepped !== e.zst)
               report_mismatch("main_stepped", rsp_main_stepped, e.zst);
            if (rsp_follow_stepped !== e.fst)
               report_mismatch("follow_stepped", rsp_follow_stepped, e.fst);
            if (rsp_moving !== e.mov) report_mismatch("moving", rsp_moving, e.mov);
            if (rsp_release_res !== e.rel)
               report_mismatch("release_res", rsp_release_res, e.rel);
         end
      end
   end

   // Receiver stall, with an optional long hold-off.
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall);
      end
   end

   // Watchdog on cycles without any accepted beat.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet <= 0;
      else
         quiet <= quiet + 1;
      if (quiet > 20000) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Returns at the falling edge after acceptance with valid still raised; the
   // next beat, an idle cycle or drain_results lowers or reuses it.
   task automatic send_beat(input logic [2:0] cmd, input logic signed [15:0] pv,
                            input bit fwd, input bit fen, input logic [3:0] ti,
                            input logic signed [15:0] tz, input logic signed [15:0] tf);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_position_value <= pv;
      req_forward <= fwd;
      req_follow_enable <= fen;
      req_table_index <= ti;
      req_table_zoom <= tz;
      req_table_focus <= tf;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_motion(cmd, pv, fwd, fen, ti, tz, tf);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_beats.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_MAIN_PHASE_COUNT: m_zcnt = val & 16'h7F;
         CSR_FOLLOW_PHASE_COUNT: m_fcnt = val & 16'h7F;
         CSR_STEP_PERIOD: m_period = val;
         CSR_FOLLOW_LIMIT: m_flimit = int'(signed'(val));
         CSR_LOWER_LIMIT: m_lower = int'(signed'(val));
         CSR_UPPER_LIMIT: m_upper = int'(signed'(val));
         CSR_HOME_POSITION: m_home = int'(signed'(val));
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic apply_settings(input int zc, input int fc, input int per, input int fl,
                                 input int lo, input int hi, input int hm);
      write_register(CSR_MAIN_PHASE_COUNT, zc[15:0]);
      write_register(CSR_FOLLOW_PHASE_COUNT, fc[15:0]);
      write_register(CSR_STEP_PERIOD, per[15:0]);
      write_register(CSR_FOLLOW_LIMIT, fl[15:0]);
      write_register(CSR_LOWER_LIMIT, lo[15:0]);
      write_register(CSR_UPPER_LIMIT, hi[15:0]);
      write_register(CSR_HOME_POSITION, hm[15:0]);
      csr_valid <= 1'b0;
   endtask

   // Loads a non-decreasing curve near the current zoom region, random slopes.
   task automatic load_curve(input int base);
      int z, f;
      z = base;
      for (int i = 0; i < 16; i++) begin
         f = $urandom_range(65535) - 32768;
         if ($urandom_range(9) == 0) f = ($urandom_range(1)) ? 32767 : -32768;
         send_beat(CMD_LOAD_TABLE, 0, 0, 0, i[3:0], z[15:0], f[15:0]);
         z = z + (($urandom_range(7) == 0) ? 0 : $urandom_range(1, 12));
         if (z > 32767) z = 32767;
      end
   endtask

   task automatic random_traffic(input int count);
      int r, pv;
      logic [2:0] cmd;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(99);
         pv = m_zpos + $urandom_range(10) - 5;
         if ($urandom_range(15) == 0) pv = $urandom_range(65535);
         cmd = (r < 55) ? CMD_TICK : (r < 70) ? CMD_MOVE_TO : (r < 76) ? CMD_MOVE_LIMIT :
               (r < 79) ? CMD_HOME : (r < 84) ? CMD_STOP : (r < 89) ? CMD_SET_MAIN :
               (r < 95) ? CMD_SET_FOLLOW : CMD_LOAD_TABLE;
         if (cmd == CMD_SET_FOLLOW && $urandom_range(1)) pv = m_fpos + $urandom_range(6) - 3;
         if (cmd == CMD_LOAD_TABLE && $urandom_range(3) == 0)
            send_beat(cmd, 16'($urandom), 1'b1, 1'b1, 4'($urandom_range(15)),
                      16'(m_zpos + n % 7), 16'($urandom));
         else if (cmd == CMD_LOAD_TABLE)
            send_beat(CMD_TICK, 16'($urandom), 1'($urandom), 1'($urandom), 4'($urandom),
                      16'($urandom), 16'($urandom));
         else
            send_beat(cmd, pv[15:0], 1'($urandom_range(1)), $urandom_range(3) != 0,
                      4'($urandom), 16'($urandom), 16'($urandom));
      end
   endtask

   typedef struct {
      logic [2:0] cmd;
      int pv;
      bit fwd;
      bit fen;
      bit known;
      int zpos;
      bit mov;
      bit rel;
   } directed_row_type;

   directed_row_type rows[$];

   initial begin
      m_zcnt = 8; m_fcnt = 8; m_period = 1; m_flimit = 32767;
      m_lower = 0; m_upper = 3000; m_home = 0;
      {m_zpos, m_zgoal, m_fpos, m_fgoal, m_zph, m_fph, m_pcount} = '0;
      m_busy = 0; m_track = 0;
      foreach (m_tz[i]) begin
         m_tz[i] = 0; m_tf[i] = 0;
      end
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed rows; known results are checked here as well as by the predictor.
      rows = '{
         '{CMD_TICK, 0, 0, 0, 1, 0, 0, 0},
         '{CMD_STOP, 0, 0, 0, 1, 0, 0, 0},
         '{CMD_MOVE_TO, 0, 0, 0, 1, 0, 0, 1},
         '{CMD_SET_MAIN, 32767, 0, 0, 1, 32767, 0, 0},
         '{CMD_SET_MAIN, -32768, 0, 0, 1, -32768, 0, 0},
         '{CMD_SET_MAIN, 2998, 0, 0, 1, 2998, 0, 0},
         '{CMD_MOVE_LIMIT, 0, 1, 0, 1, 2999, 1, 0},
         '{CMD_TICK, 0, 0, 0, 1, 3000, 1, 0},
         '{CMD_TICK, 0, 0, 0, 1, 3000, 0, 1},
         '{CMD_HOME, 0, 0, 0, 1, 2999, 1, 0},
         '{CMD_STOP, 0, 0, 0, 1, 2999, 0, 1},
         '{CMD_SET_FOLLOW, -32768, 0, 0, 0, 0, 0, 0},
         '{CMD_SET_FOLLOW, 32767, 0, 0, 0, 0, 0, 0},
         '{CMD_SET_FOLLOW, 0, 0, 0, 0, 0, 0, 0},
         '{CMD_SET_MAIN, 0, 0, 0, 0, 0, 0, 0},
         '{CMD_MOVE_LIMIT, 0, 0, 0, 0, 0, 0, 0}
      };
      foreach (rows[i]) begin
         send_beat(rows[i].cmd, rows[i].pv[15:0], rows[i].fwd, rows[i].fen, 0, 0, 0);
         if (rows[i].known) begin
            if (m_zpos != rows[i].zpos) report_mismatch("row position", m_zpos, rows[i].zpos);
            if (m_busy != rows[i].mov) report_mismatch("row moving", m_busy, rows[i].mov);
            if (m_rel != rows[i].rel) report_mismatch("row release", m_rel, rows[i].rel);
         end
      end
      // Table with extremes and equal breakpoints, then moves past both ends.
      for (int i = 0; i < 16; i++)
         send_beat(CMD_LOAD_TABLE, 0, 0, 0, i[3:0], 16'(i < 2 ? 10 : i * 10),
                   (i % 2) ? 16'sh7FFF : 16'sh8000);
      send_beat(CMD_MOVE_TO, 200, 0, 1, 0, 0, 0);
      send_beat(CMD_MOVE_TO, -5, 0, 1, 0, 0, 0);
      drain_results();

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: apply_settings(1, 64, 1, 32767, -32768, 32767, -32768);
            1: apply_settings(64, 1, 3, -32768, m_zpos - 20, m_zpos + 20, m_zpos);
            2: apply_settings($urandom_range(2, 63), $urandom_range(2, 63), 2,
                              $urandom_range(65535) - 32768, m_zpos - 9, m_zpos + 9, m_zpos);
            default: apply_settings(0, 127, 0, 30000, m_zpos - 30, m_zpos + 30, m_zpos + 3);
         endcase
         send_idle = (ph == 1 || ph == 3) ? 60 : (ph == 2) ? 9 : 0;
         recv_stall = (ph == 2 || ph == 3) ? 60 : (ph == 1) ? 9 : 0;
         load_curve(m_zpos - 40);
         if (ph == 2) begin
            req_valid <= 1'b0;
            hold_cycles <= 400;
            @(negedge clock);
         end
         random_traffic(170);
         drain_results();
      end
      apply_settings(8, 8, 65535, 32767, 0, 3000, 0);
      send_beat(CMD_MOVE_TO, 16'(m_zpos + 100), 0, 0, 0, 0, 0);
      send_beat(CMD_TICK, 0, 0, 0, 0, 0, 0);
      drain_results();

      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule

// ===== zoom_focus_stepper_tracker_core.f =====
rtl/zfst_pkg.sv
rtl/zfst_dpath.sv
rtl/zfst_ctrl.sv
rtl/zoom_focus_stepper_tracker_core.sv
bench/tb.sv
